FILE: hw/rtl/desa_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// desa_pkg
// Shared constants, opcodes and controller/datapath handshake types for the
// double-ended stack allocator.
// ----------------------------------------------------------------------------
package desa_pkg;

  localparam int BUFFER_BYTES = 4096;
  localparam int HEADER_BYTES = 4;
  localparam int ADDR_W       = $clog2(BUFFER_BYTES);
  localparam int TOP_W        = ADDR_W + 1;
  localparam int CALC_W       = TOP_W + 5;

  localparam logic [1:0] OP_ALLOC = 2'd0;
  localparam logic [1:0] OP_FREE  = 2'd1;
  localparam logic [1:0] OP_RESET = 2'd2;

  typedef struct packed {
    logic capture;
    logic calc;
    logic commit;
  } desa_cmd_t;

  typedef struct packed {
    logic out_busy;
  } desa_status_t;

  // Mask of the bits below the highest set bit: alignment minus one after
  // rounding down to a power of two. Zero gives an empty mask.
  function automatic logic [ADDR_W-1:0] align_mask(input logic [TOP_W-1:0] a);
    logic [ADDR_W-1:0] m;
    for (int i = 0; i < ADDR_W; i++) begin
      m[i] = (a >> (i + 1)) != '0;
    end
    return m;
  endfunction

endpackage

FILE: hw/rtl/desa_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// desa_if
// Request and response channel interfaces of the stack allocator.
// ----------------------------------------------------------------------------
interface desa_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  op;
  logic        side;
  logic [12:0] request_bytes;
  logic [12:0] alignment;
  logic [12:0] align_offset;
  logic [11:0] free_address;

  modport source (output valid, op, side, request_bytes, alignment, align_offset,
                  free_address, input ready);
  modport sink (input valid, op, side, request_bytes, alignment, align_offset,
                free_address, output ready);
endinterface

interface desa_rsp_if;
  logic        valid;
  logic        ready;
  logic [11:0] user_address;
  logic        success;

  modport source (output valid, user_address, success, input ready);
  modport sink (input valid, user_address, success, output ready);
endinterface

FILE: hw/rtl/desa_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// desa_ctrl
// Sequencer: accept a request, align, then check and commit the result.
// ----------------------------------------------------------------------------
module desa_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  req_valid,
  output logic                  req_ready,
  input  desa_pkg::desa_status_t status,
  output desa_pkg::desa_cmd_t    cmd
);
  import desa_pkg::*;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_CALC  = 2'd1;
  localparam logic [1:0] S_CHECK = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next  = state;
    cmd         = '0;
    req_ready   = 1'b0;
    case (state)
      S_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          cmd.capture = 1'b1;
          state_next  = S_CALC;
        end
      end
      S_CALC: begin
        cmd.calc   = 1'b1;
        state_next = S_CHECK;
      end
      S_CHECK: begin
        // hold until the output register can take the result
        if (!status.out_busy) begin
          cmd.commit = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

FILE: hw/rtl/desa_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// desa_datapath
// Stack tops, header memory, alignment arithmetic and output register.
// ----------------------------------------------------------------------------
module desa_datapath (
  input  logic                   clk,
  input  logic                   rst,
  input  desa_pkg::desa_cmd_t    cmd,
  output desa_pkg::desa_status_t status,
  input  logic                   cfg_we,
  input  logic [12:0]            cfg_wdata,
  input  logic [1:0]             op,
  input  logic                   side,
  input  logic [12:0]            request_bytes,
  input  logic [12:0]            alignment,
  input  logic [12:0]            align_offset,
  input  logic [11:0]            free_address,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [11:0]            user_address,
  output logic                   success
);
  import desa_pkg::*;

  logic [TOP_W-1:0] buffer_size;
  logic [TOP_W-1:0] size;
  logic [TOP_W-1:0] left_top;
  logic [TOP_W-1:0] right_top;

  logic [TOP_W-1:0] header_store [BUFFER_BYTES];
  logic [TOP_W-1:0] rd_data;

  // captured request
  logic [1:0]               op_q;
  logic                     side_q;
  logic                     req_nz_q;
  logic [ADDR_W-1:0]        m_q;
  logic [TOP_W:0]           no_q;
  logic signed [CALC_W-1:0] d_q;
  logic [TOP_W+1:0]         lno_q;
  logic signed [CALC_W-1:0] lim_q;
  logic                     rt_ok_q;
  logic signed [CALC_W-1:0] base_q;

  logic [TOP_W:0]           no_c;
  logic signed [CALC_W-1:0] sum_c;
  logic signed [CALC_W-1:0] cur;
  logic signed [CALC_W-1:0] top;
  logic signed [CALC_W-1:0] size_s;
  logic signed [CALC_W-1:0] ltop_s;
  logic signed [CALC_W-1:0] lim_buf;
  logic                     ok_l;
  logic                     ok_r;
  logic                     alloc_ok;

  assign size   = (buffer_size > TOP_W'(BUFFER_BYTES)) ? TOP_W'(BUFFER_BYTES) : buffer_size;
  assign size_s = $signed({{(CALC_W-TOP_W){1'b0}}, size});
  assign ltop_s = $signed({{(CALC_W-TOP_W){1'b0}}, left_top});
  assign lim_buf = $signed(CALC_W'(BUFFER_BYTES));
  assign no_c   = {1'b0, align_offset} + (TOP_W+1)'(HEADER_BYTES);

  assign status.out_busy = out_valid && !out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      buffer_size <= TOP_W'(BUFFER_BYTES);
    end else if (cfg_we) begin
      buffer_size <= cfg_wdata;
    end
  end

  // stage 1: capture operands and the precomputed sums
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_q     <= op;
      side_q   <= side;
      req_nz_q <= request_bytes != '0;
      m_q      <= align_mask(alignment);
      no_q     <= no_c;
      d_q      <= $signed({{(CALC_W-TOP_W){1'b0}}, request_bytes})
                - $signed({{(CALC_W-TOP_W){1'b0}}, align_offset});
      lno_q    <= {2'b00, left_top} + {1'b0, no_c};
      lim_q    <= size_s - $signed({{(CALC_W-TOP_W){1'b0}}, right_top});
      rt_ok_q  <= right_top <= size;
    end
  end

  // stage 2: round up (left) or down (right) to the alignment boundary
  always_comb begin
    if (side_q) begin
      sum_c = lim_q - d_q;
    end else begin
      sum_c = $signed({{(CALC_W-TOP_W-2){1'b0}}, lno_q})
            + $signed({{(CALC_W-ADDR_W){1'b0}}, m_q});
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.calc) begin
      base_q <= sum_c & ~$signed({{(CALC_W-ADDR_W){1'b0}}, m_q});
    end
  end

  // stage 3: header address, new top and the overlap checks
  assign cur = base_q - $signed({{(CALC_W-TOP_W-1){1'b0}}, no_q});
  assign top = base_q + d_q;
  assign ok_l = (top <= size_s) && rt_ok_q && (top < lim_q) && (cur < lim_buf);
  assign ok_r = (cur > ltop_s) && (cur < size_s) && (cur < lim_buf);
  assign alloc_ok = req_nz_q && (side_q ? ok_r : ok_l);

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      rd_data <= header_store[free_address - ADDR_W'(HEADER_BYTES)];
    end
    if (cmd.commit && op_q == OP_ALLOC && alloc_ok) begin
      header_store[cur[ADDR_W-1:0]] <= side_q ? right_top : left_top;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      left_top  <= '0;
      right_top <= '0;
    end else if (cmd.commit) begin
      case (op_q)
        OP_RESET: begin
          left_top  <= '0;
          right_top <= '0;
        end
        OP_FREE: begin
          if (side_q) begin
            right_top <= rd_data;
          end else begin
            left_top <= rd_data;
          end
        end
        OP_ALLOC: begin
          if (alloc_ok) begin
            if (side_q) begin
              right_top <= size - cur[TOP_W-1:0];
            end else begin
              left_top <= top[TOP_W-1:0];
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.commit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      case (op_q)
        OP_RESET, OP_FREE: begin
          user_address <= '0;
          success      <= 1'b1;
        end
        OP_ALLOC: begin
          user_address <= alloc_ok ? cur[ADDR_W-1:0] + ADDR_W'(HEADER_BYTES) : '0;
          success      <= alloc_ok;
        end
        default: begin
          user_address <= '0;
          success      <= 1'b0;
        end
      endcase
    end
  end

endmodule

FILE: hw/rtl/double_ended_stack_allocator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// double_ended_stack_allocator
// Two stacks in one buffer growing toward each other, with saved headers.
// ----------------------------------------------------------------------------
// Channels: req carries one command per transaction (allocate, free, reset
// both stacks); rsp returns one user_address/success pair per request, in
// order. cfg_we/cfg_wdata write buffer_size; write it only while idle.
// Timing: a request is taken in the idle cycle, the alignment sum is formed
// in the next, and the checks and state update happen in the check step,
// which loads the output register. A new request is taken only after the
// previous one commits, and that commit registers the response. The
// three-step sequencer and the registered header read pace the requests.
// A new request is taken while the previous response still waits in the
// output register; if rsp stays stalled, the sequencer holds in its last
// step until the register frees up, and req.ready stays low meanwhile.
// Reset clears both stack tops and sets buffer_size to 4096. The header
// memory is not cleared: a free must name an address that an earlier
// allocate returned.
// ----------------------------------------------------------------------------
module double_ended_stack_allocator (
  input  logic        clk,
  input  logic        rst,
  desa_req_if.sink    req,
  desa_rsp_if.source  rsp,
  input  logic        cfg_we,
  input  logic [12:0] cfg_wdata
);
  import desa_pkg::*;

  desa_cmd_t    cmd;
  desa_status_t status;

  desa_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .status    (status),
    .cmd       (cmd)
  );

  desa_datapath u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .status        (status),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .op            (req.op),
    .side          (req.side),
    .request_bytes (req.request_bytes),
    .alignment     (req.alignment),
    .align_offset  (req.align_offset),
    .free_address  (req.free_address),
    .out_valid     (rsp.valid),
    .out_ready     (rsp.ready),
    .user_address  (rsp.user_address),
    .success       (rsp.success)
  );

endmodule

FILE: hw/rtl/desa_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// desa_checker
// Port-level checks on the allocator's request/response ordering.
// ----------------------------------------------------------------------------
module desa_checker (
  input logic        clk,
  input logic        rst,
  input logic        req_valid,
  input logic        req_ready,
  input logic        rsp_valid,
  input logic        rsp_ready,
  input logic [11:0] rsp_user_address,
  input logic        rsp_success
);

  logic       req_fire;
  logic       rsp_fire;
  logic [1:0] pending;

  assign req_fire = req_valid && req_ready;
  assign rsp_fire = rsp_valid && rsp_ready;

  // requests accepted but not yet answered
  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
    end else begin
      pending <= pending + {1'b0, req_fire} - {1'b0, rsp_fire};
    end
  end

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_user_address)
      && $stable(rsp_success))
    else $error("response changed while stalled");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    req_fire |=> !req_ready)
    else $error("request taken while previous one in progress");

  a_no_spurious_rsp: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> pending != 2'd0)
    else $error("response without an outstanding request");

  a_bounded_pending: assert property (@(posedge clk) disable iff (rst)
    req_fire |-> pending < 2'd2)
    else $error("more than one response backed up");

endmodule

bind double_ended_stack_allocator desa_checker u_desa_checker (
  .clk              (clk),
  .rst              (rst),
  .req_valid        (req.valid),
  .req_ready        (req.ready),
  .rsp_valid        (rsp.valid),
  .rsp_ready        (rsp.ready),
  .rsp_user_address (rsp.user_address),
  .rsp_success      (rsp.success)
);
